>>> rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DSA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent at the next clock edge.
`define DSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/dsa_pkg.sv
// Shared types, widths and codes for the descriptor slot allocator.
// No dependencies; imported by the top, dsa_csr, dsa_ctrl and the bench.
package dsa_pkg;

   localparam int SLOT_COUNT = 512;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int CNT_W      = SLOT_W + 1;
   localparam int IN_SLOT_W  = 16;
   localparam int ADDR_W     = 64;
   localparam int STRIDE_W   = 12;
   localparam int OFF_W      = STRIDE_W + SLOT_W;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CNT_W-1:0]     SLOT_COUNT_C = CNT_W'(SLOT_COUNT);
   localparam logic [IN_SLOT_W:0]   SLOT_LIMIT   = (IN_SLOT_W + 1)'(SLOT_COUNT);
   localparam logic [STRIDE_W-1:0]  STRIDE_RESET = STRIDE_W'(32);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_RESERVED  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_ALLOC = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_CPU_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GPU_BASE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE   = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0]   cpu_base;
      logic [ADDR_W-1:0]   gpu_base;
      logic [STRIDE_W-1:0] stride;
   } cfg_type;

   typedef enum logic {
      ST_IDLE,
      ST_WORK
   } state_type;

endpackage

>>> rtl/descriptor_slot_allocator_top.sv
// Descriptor slot allocator: free stack, allocation map, configuration and sequencer.
// Depends on dsa_pkg, dsa_ram, dsa_csr and dsa_ctrl.
//
// Usage:
//   req channel: one beat per request; req_cmd selects allocate or free,
//     req_slot_in names the slot to free. rsp channel: one beat per request,
//     in order, carrying status, slot, CPU/GPU handles and can_allocate.
//   csr channel: csr_index 0 CPU heap base, 1 GPU heap base, 2 stride;
//     always ready; write only while no request is outstanding.
//   A request beat registers its command and slot and starts the RAM reads;
//     the result register loads once it is empty or being taken. A new request
//     waits for the read-modify-write of stack top and map bit in the RAMs.
//   Handles are base + stride * slot, added at the output from a registered
//     offset; they read zero for frees and refused allocations.
//   Reset: free count and handshakes clear, the fresh counter is 1, stride is 32;
//     no RAM clear pass is needed, map entries above the fresh counter read clear.
//   Stall: with rsp_ready low the result holds; one further request may be
//     taken and waits in the sequencer until the result register frees.
module descriptor_slot_allocator_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [dsa_pkg::IN_SLOT_W-1:0]  req_slot_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dsa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [dsa_pkg::SLOT_W-1:0]     rsp_slot_out,
   output logic [dsa_pkg::ADDR_W-1:0]     rsp_cpu_handle,
   output logic [dsa_pkg::ADDR_W-1:0]     rsp_gpu_handle,
   output logic                           rsp_can_allocate,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dsa_pkg::ADDR_W-1:0]     csr_data
);
   import dsa_pkg::*;

   cfg_type cfg;

   logic              stk_rd_en, stk_wr_en, map_rd_en, map_wr_en;
   logic [SLOT_W-1:0] stk_rd_addr, stk_rd_data, stk_wr_addr, stk_wr_data;
   logic [SLOT_W-1:0] map_rd_addr, map_wr_addr;
   logic [0:0]        map_rd_data, map_wr_data;

   dsa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dsa_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_stack (
      .clock   (clock),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data)
   );

   dsa_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_map (
      .clock   (clock),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data)
   );

   dsa_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_slot_in      (req_slot_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_cpu_handle   (rsp_cpu_handle),
      .rsp_gpu_handle   (rsp_gpu_handle),
      .rsp_can_allocate (rsp_can_allocate),
      .stk_rd_en        (stk_rd_en),
      .stk_rd_addr      (stk_rd_addr),
      .stk_rd_data      (stk_rd_data),
      .stk_wr_en        (stk_wr_en),
      .stk_wr_addr      (stk_wr_addr),
      .stk_wr_data      (stk_wr_data),
      .map_rd_en        (map_rd_en),
      .map_rd_addr      (map_rd_addr),
      .map_rd_data      (map_rd_data),
      .map_wr_en        (map_wr_en),
      .map_wr_addr      (map_wr_addr),
      .map_wr_data      (map_wr_data)
   );

endmodule

>>> rtl/dsa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the free stack and the allocation map.
module dsa_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 512,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/dsa_csr.sv
// Configuration registers: heap bases and descriptor stride.
// Depends on dsa_pkg.
module dsa_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dsa_pkg::ADDR_W-1:0]     csr_data,
   output dsa_pkg::cfg_type               cfg
);
   import dsa_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CPU_BASE: cfg_in.cpu_base = csr_data;
            CSR_GPU_BASE: cfg_in.gpu_base = csr_data;
            CSR_STRIDE:   cfg_in.stride   = csr_data[STRIDE_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cpu_base <= '0;
         cfg_ff.gpu_base <= '0;
         cfg_ff.stride   <= STRIDE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/dsa_ctrl.sv
// Request sequencer: reads stack top and map bit, updates them, forms the result.
// Depends on dsa_pkg and assert_macros.svh; drives the two dsa_ram instances.
`include "assert_macros.svh"

module dsa_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  dsa_pkg::cfg_type               cfg,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [dsa_pkg::IN_SLOT_W-1:0]  req_slot_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dsa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [dsa_pkg::SLOT_W-1:0]     rsp_slot_out,
   output logic [dsa_pkg::ADDR_W-1:0]     rsp_cpu_handle,
   output logic [dsa_pkg::ADDR_W-1:0]     rsp_gpu_handle,
   output logic                           rsp_can_allocate,
   output logic                           stk_rd_en,
   output logic [dsa_pkg::SLOT_W-1:0]     stk_rd_addr,
   input  logic [dsa_pkg::SLOT_W-1:0]     stk_rd_data,
   output logic                           stk_wr_en,
   output logic [dsa_pkg::SLOT_W-1:0]     stk_wr_addr,
   output logic [dsa_pkg::SLOT_W-1:0]     stk_wr_data,
   output logic                           map_rd_en,
   output logic [dsa_pkg::SLOT_W-1:0]     map_rd_addr,
   input  logic [0:0]                     map_rd_data,
   output logic                           map_wr_en,
   output logic [dsa_pkg::SLOT_W-1:0]     map_wr_addr,
   output logic [0:0]                     map_wr_data
);
   import dsa_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]     free_count_ff, free_count_in;
   logic [CNT_W-1:0]     next_fresh_ff, next_fresh_in;
   logic                 cmd_ff;
   logic [IN_SLOT_W-1:0] slot_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [OFF_W-1:0]     rsp_off_ff, rsp_off_in;
   logic                 rsp_grant_ff, rsp_grant_in;
   logic                 rsp_can_ff, rsp_can_in;

   logic                 accept;
   logic                 advance;
   logic                 map_hit;
   logic [SLOT_W-1:0]    grant;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_WORK;
         ST_WORK: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      advance   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_WORK: advance   = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   assign stk_rd_en   = accept;
   assign stk_rd_addr = SLOT_W'(free_count_ff - CNT_W'(1));
   assign map_rd_en   = accept;
   assign map_rd_addr = req_slot_in[SLOT_W-1:0];

   // map entries at or above the fresh counter have never been written
   assign map_hit = ({1'b0, slot_ff[SLOT_W-1:0]} < next_fresh_ff) && map_rd_data[0];

   always_comb begin
      free_count_in = free_count_ff;
      next_fresh_in = next_fresh_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_grant_in  = rsp_grant_ff;
      stk_wr_en     = 1'b0;
      stk_wr_addr   = free_count_ff[SLOT_W-1:0];
      stk_wr_data   = slot_ff[SLOT_W-1:0];
      map_wr_en     = 1'b0;
      map_wr_addr   = slot_ff[SLOT_W-1:0];
      map_wr_data   = 1'b0;
      grant         = '0;

      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_grant_in = 1'b0;
         rsp_off_in   = '0;
         if (cmd_ff == CMD_ALLOC) begin
            rsp_status_in = STAT_OK;
            if (free_count_ff != '0 && free_count_ff <= SLOT_COUNT_C) begin
               grant         = stk_rd_data;
               free_count_in = free_count_ff - CNT_W'(1);
            end else if (next_fresh_ff < SLOT_COUNT_C) begin
               grant         = next_fresh_ff[SLOT_W-1:0];
               next_fresh_in = next_fresh_ff + CNT_W'(1);
            end else begin
               rsp_status_in = STAT_EXHAUSTED;
            end
            rsp_slot_in = grant;
            if (rsp_status_in == STAT_OK) begin
               rsp_grant_in = 1'b1;
               rsp_off_in   = OFF_W'(cfg.stride) * OFF_W'(grant);
               map_wr_en    = 1'b1;
               map_wr_addr  = grant;
               map_wr_data  = 1'b1;
            end
         end else begin
            rsp_slot_in = slot_ff[SLOT_W-1:0];
            if (slot_ff == '0) begin
               rsp_status_in = STAT_RESERVED;
            end else if ({1'b0, slot_ff} >= SLOT_LIMIT) begin
               rsp_status_in = STAT_RANGE;
            end else if (!map_hit) begin
               rsp_status_in = STAT_NOT_ALLOC;
            end else begin
               rsp_status_in = STAT_OK;
               map_wr_en     = 1'b1;
               map_wr_data   = 1'b0;
               if (free_count_ff < SLOT_COUNT_C) begin
                  stk_wr_en     = 1'b1;
                  free_count_in = free_count_ff + CNT_W'(1);
               end
            end
         end
      end
   end

   assign rsp_can_in = advance ? (next_fresh_in < SLOT_COUNT_C) : rsp_can_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_count_ff <= '0;
         next_fresh_ff <= CNT_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_count_ff <= free_count_in;
         next_fresh_ff <= next_fresh_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         slot_ff <= req_slot_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_can_ff    <= rsp_can_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_out     = rsp_slot_ff;
   assign rsp_can_allocate = rsp_can_ff;
   assign rsp_cpu_handle   = rsp_grant_ff ? cfg.cpu_base + ADDR_W'(rsp_off_ff) : '0;
   assign rsp_gpu_handle   = rsp_grant_ff ? cfg.gpu_base + ADDR_W'(rsp_off_ff) : '0;

   `DSA_ASSERT(a_count_bound, clock, reset, free_count_ff < next_fresh_ff, "free count not below fresh counter")
   `DSA_ASSERT(a_fresh_range, clock, reset, next_fresh_ff != '0 && next_fresh_ff <= SLOT_COUNT_C, "fresh counter out of range")
   `DSA_ASSERT_NEXT(a_fresh_step, clock, reset, advance && cmd_ff == CMD_ALLOC && free_count_ff == '0 && next_fresh_ff < SLOT_COUNT_C, next_fresh_ff == $past(next_fresh_ff) + CNT_W'(1) && rsp_slot_ff == $past(next_fresh_ff[SLOT_W-1:0]), "fresh grant not taken from counter")
   `DSA_ASSERT(a_one_in_flight, clock, reset, !(accept && (map_wr_en || stk_wr_en)), "request overlapped with write-back")

endmodule

>>> dv/tb_top.sv
// Self-checking bench for descriptor_slot_allocator_top: drives allocate/free beats and CSR
// writes, predicts every response beat in a scoreboard class and compares them field by field.
// Depends on dsa_pkg and the allocator RTL only.
module tb_top;
   import dsa_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [ADDR_W-1:0]   cpu_handle;
      logic [ADDR_W-1:0]   gpu_handle;
      logic                can_allocate;
   } grant_beat_type;

   class slot_ledger_type;
      cfg_type           cfg = '{cpu_base: '0, gpu_base: '0, stride: STRIDE_RESET};
      logic [SLOT_W-1:0] free_stack [SLOT_COUNT];
      int                free_top = 0;
      int                next_fresh = 1;
      bit                in_use [SLOT_COUNT];
      grant_beat_type    due_results [$];
      int                errors = 0;

      task report(input string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         errors++;
      endtask

      function void set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
         case (idx)
            CSR_CPU_BASE: cfg.cpu_base = data;
            CSR_GPU_BASE: cfg.gpu_base = data;
            CSR_STRIDE:   cfg.stride = data[STRIDE_W-1:0];
            default: ;
         endcase
      endfunction

      function bit exhausted();
         return free_top == 0 && next_fresh >= SLOT_COUNT;
      endfunction

      // random live slot, or zero when nothing is allocated
      function logic [IN_SLOT_W-1:0] pick_live();
         int s;
         int n;
         s = $urandom_range(SLOT_COUNT - 1, 1);
         for (n = 0; n < SLOT_COUNT; n++) begin
            if (in_use[s]) return IN_SLOT_W'(s);
            s = (s == SLOT_COUNT - 1) ? 1 : s + 1;
         end
         return '0;
      endfunction

      function void note_request(input logic cmd, input logic [IN_SLOT_W-1:0] slot_in);
         grant_beat_type    b;
         logic [SLOT_W-1:0] grant;
         logic [ADDR_W-1:0] off;
         bit                granted;
         b = '0;
         grant = '0;
         granted = 1'b0;
         if (cmd == CMD_ALLOC) begin
            if (free_top > 0) begin
               free_top--;
               grant = free_stack[free_top];
               granted = 1'b1;
            end else if (next_fresh < SLOT_COUNT) begin
               grant = SLOT_W'(next_fresh);
               next_fresh++;
               granted = 1'b1;
            end else
               b.status = STAT_EXHAUSTED;
            if (granted) begin
               in_use[grant] = 1'b1;
               off = ADDR_W'(cfg.stride) * ADDR_W'(grant);
               b.status = STAT_OK;
               b.slot = grant;
               b.cpu_handle = cfg.cpu_base + off;
               b.gpu_handle = cfg.gpu_base + off;
            end
         end else begin
            b.slot = slot_in[SLOT_W-1:0];
            if (slot_in == '0)
               b.status = STAT_RESERVED;
            else if (slot_in >= SLOT_COUNT)
               b.status = STAT_RANGE;
            else if (!in_use[slot_in[SLOT_W-1:0]])
               b.status = STAT_NOT_ALLOC;
            else begin
               in_use[slot_in[SLOT_W-1:0]] = 1'b0;
               free_stack[free_top] = slot_in[SLOT_W-1:0];
               free_top++;
               b.status = STAT_OK;
            end
         end
         b.can_allocate = (next_fresh < SLOT_COUNT);
         due_results = {due_results, b};
      endfunction

      task check_result(input grant_beat_type got);
         grant_beat_type want;
         if (due_results.size() == 0) begin
            report($sformatf("unexpected beat status %0d slot %0d", got.status, got.slot));
            return;
         end
         want = due_results.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.slot !== want.slot)
            report($sformatf("slot %0d, want %0d", got.slot, want.slot));
         if (got.cpu_handle !== want.cpu_handle)
            report($sformatf("cpu handle %h, want %h", got.cpu_handle, want.cpu_handle));
         if (got.gpu_handle !== want.gpu_handle)
            report($sformatf("gpu handle %h, want %h", got.gpu_handle, want.gpu_handle));
         if (got.can_allocate !== want.can_allocate)
            report($sformatf("can_allocate %b, want %b", got.can_allocate, want.can_allocate));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_cmd;
   logic [IN_SLOT_W-1:0]  req_slot_in;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]     rsp_slot_out;
   logic [ADDR_W-1:0]     rsp_cpu_handle;
   logic [ADDR_W-1:0]     rsp_gpu_handle;
   logic                  rsp_can_allocate;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [ADDR_W-1:0]     csr_data;

   int              req_idle_pct = 16;
   int              rsp_stall_pct = 65;
   slot_ledger_type book = new;

   descriptor_slot_allocator_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_slot_in      (req_slot_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_cpu_handle   (rsp_cpu_handle),
      .rsp_gpu_handle   (rsp_gpu_handle),
      .rsp_can_allocate (rsp_can_allocate),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_result({rsp_status, rsp_slot_out, rsp_cpu_handle, rsp_gpu_handle,
                            rsp_can_allocate});
   end

   // valid stays up across back-to-back beats; it only drops for a gap or a pause
   task automatic send_req(input logic cmd, input logic [IN_SLOT_W-1:0] slot);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_slot_in <= slot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.note_request(cmd, slot);
   endtask

   task automatic random_item(input int alloc_pct);
      int                   pick;
      logic [IN_SLOT_W-1:0] slot;
      pick = $urandom_range(99);
      slot = IN_SLOT_W'($urandom);
      if (pick < alloc_pct)
         send_req(CMD_ALLOC, slot);
      else begin
         pick = $urandom_range(99);
         if (pick < 65)
            slot = book.pick_live();
         else if (pick < 80)
            slot = IN_SLOT_W'($urandom_range(SLOT_COUNT - 1, 1));
         else if (pick < 87)
            slot = '0;
         else if (pick < 95)
            slot = IN_SLOT_W'($urandom_range(65535, SLOT_COUNT));
         send_req(CMD_FREE, slot);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (book.due_results.size() != 0);
   endtask

   task automatic csr_beat(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      book.set_reg(idx, data);
   endtask

   task automatic configure(input logic [ADDR_W-1:0] cpu, input logic [ADDR_W-1:0] gpu,
                            input logic [STRIDE_W-1:0] stride, input bit poke_spare);
      settle();
      csr_beat(CSR_CPU_BASE, cpu);
      csr_beat(CSR_GPU_BASE, gpu);
      // upper data bits are junk and must be dropped
      csr_beat(CSR_STRIDE, ADDR_W'({{(ADDR_W-STRIDE_W)/32+1{$urandom}}, stride}));
      if (poke_spare)
         csr_beat(CSR_SPARE, {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= CMD_ALLOC;
      req_slot_in <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_CPU_BASE;
      csr_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, fresh grants, LIFO reuse, reserved/range/not-allocated refusals
      send_req(CMD_ALLOC, 16'hFFFF);
      send_req(CMD_ALLOC, 16'h0000);
      send_req(CMD_ALLOC, 16'h1234);
      send_req(CMD_FREE, 16'd2);
      send_req(CMD_FREE, 16'd2);
      send_req(CMD_ALLOC, 16'h0000);
      send_req(CMD_FREE, 16'd3);
      send_req(CMD_FREE, 16'd1);
      send_req(CMD_ALLOC, 16'h0000);
      send_req(CMD_ALLOC, 16'h0000);
      send_req(CMD_FREE, 16'd0);
      send_req(CMD_FREE, 16'd511);
      send_req(CMD_FREE, 16'd512);
      send_req(CMD_FREE, 16'hFFFF);
      send_req(CMD_FREE, 16'h8000);
      send_req(CMD_FREE, 16'h5A5A);
      send_req(CMD_FREE, 16'd1);
      send_req(CMD_FREE, 16'd1);

      configure('1, '0, 12'hFFF, 1'b0);
      repeat (200) random_item(55);

      req_idle_pct = 65;
      rsp_stall_pct = 16;
      configure({$urandom, $urandom}, '1, 12'h000, 1'b0);
      while (!book.exhausted()) random_item(95);
      repeat (8) send_req(CMD_ALLOC, IN_SLOT_W'($urandom));
      // hold off until the pipe has drained
      settle();
      repeat (60) random_item(35);

      req_idle_pct = 0;
      rsp_stall_pct = 0;
      configure({$urandom, $urandom}, {$urandom, $urandom}, 12'd32, 1'b1);
      repeat (80) random_item(50);
      configure({$urandom, $urandom}, {$urandom, $urandom}, STRIDE_W'($urandom), 1'b1);
      repeat (60) random_item(50);

      settle();
      repeat (8) @(posedge clock);
      if (book.errors == 0 && book.due_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

endmodule

>>> descriptor_slot_allocator_top.f
+incdir+rtl
rtl/dsa_pkg.sv
rtl/dsa_ram.sv
rtl/dsa_csr.sv
rtl/dsa_ctrl.sv
rtl/descriptor_slot_allocator_top.sv
dv/tb_top.sv
